// ===== src/igpm_pkg.sv =====
package igpm_pkg;

  localparam int unsigned POS_W    = 31;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned DIM_W    = 12;
  localparam int unsigned IDX_W    = 2 * DIM_W;
  localparam int unsigned DCNT_W   = $clog2(IDX_W + 1);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LAYOUT = 2'd1,
    ST_FULL       = 2'd2
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] offset;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } entry_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quo;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/igpm_table.sv =====
module igpm_table
  import igpm_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/igpm_divider.sv =====
module igpm_divider
  import igpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [IDX_W-1:0]  dvd_r;
  logic [DIM_W-1:0]  rem_r;
  logic [DIM_W-1:0]  dsr_r;
  logic [DIM_W:0]    trial;
  logic [DIM_W:0]    diff;
  logic              take;

  assign trial = {rem_r, dvd_r[IDX_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign take  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.vld) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(IDX_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle; quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.vld) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= diff[DIM_W-1:0];
        dvd_r <= {dvd_r[IDX_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIM_W-1:0];
        dvd_r <= {dvd_r[IDX_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/image_grid_position_mapper_core.sv =====
// Throughput: one item at a time; a query's table walk reads one entry a cycle
// through the single table read port, then a 24-step serial divide by the grid width.
// Reset (rst_n low at a clock edge) empties the table and sets the context limit to 32768;
// table contents are not cleared, only entries below the fill count are ever read.
module image_grid_position_mapper_core
  import igpm_pkg::*;
#(
  parameter int unsigned MAX_GRIDS = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  input  logic [POS_W-1:0]        in_grid_offset,
  input  logic [DIM_W-1:0]        in_grid_rows,
  input  logic [DIM_W-1:0]        in_grid_cols,
  input  logic [POS_W-1:0]        in_physical_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_pos_temporal,
  output logic [POS_W-1:0]        out_pos_row,
  output logic [POS_W-1:0]        out_pos_col,
  output logic signed [SUM_W-1:0] out_total_shrink,
  output logic [POS_W-1:0]        out_prefix_length,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned AW = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;
  localparam int unsigned CW = $clog2(MAX_GRIDS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AP_CHK,
    S_WALK,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r;
  logic             in_acc;
  logic             out_free;

  logic [POS_W-1:0] max_ctx_r;
  logic [CW-1:0]    count_r;
  logic [POS_W-1:0] prev_end_r;
  logic [SUM_W-1:0] shrink_r;

  // append operands
  logic [POS_W-1:0] ap_off_r;
  logic [DIM_W-1:0] ap_rows_r;
  logic [DIM_W-1:0] ap_cols_r;
  logic [IDX_W-1:0] ap_prod_r;
  logic [SUM_W-1:0] ap_end;
  logic [DIM_W-1:0] ap_max;
  logic [SUM_W-1:0] ap_shrink;
  logic             ap_full;
  logic             ap_bad;

  // query walk
  logic [POS_W-1:0] phys_r;
  logic [SUM_W-1:0] delta_r;
  logic [CW-1:0]    issue_r;
  logic             rd_en;
  logic             rd_vld_r;
  logic             rd_last_r;
  entry_t           rd_data;
  logic             s2_vld_r;
  logic             s2_last_r;
  logic [POS_W-1:0] s2_off_r;
  logic [DIM_W-1:0] s2_cols_r;
  logic [IDX_W-1:0] s2_prod_r;
  logic [SUM_W-1:0] s2_shrink_r;
  logic [DIM_W-1:0] s1_max;
  logic [IDX_W-1:0] s1_prod;
  logic [POS_W-1:0] s2_idx;
  logic [SUM_W-1:0] delta_nxt;
  logic [SUM_W-1:0] start_r;

  logic             wr_en;
  entry_t           wr_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [1:0]       res_status_r;
  logic [POS_W-1:0] res_t_r;
  logic [POS_W-1:0] res_row_r;
  logic [POS_W-1:0] res_col_r;
  logic [SUM_W-1:0] outside_sum;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] col_sum;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [POS_W-1:0] out_t_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic [SUM_W-1:0] out_shrink_r;
  logic [POS_W-1:0] out_prefix_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, max_ctx_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ctx_r <= POS_W'(32768);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      max_ctx_r <= pwdata[POS_W-1:0];
    end
  end

  // append checks
  assign ap_end    = {1'b0, ap_off_r} + SUM_W'(ap_prod_r);
  assign ap_max    = (ap_rows_r > ap_cols_r) ? ap_rows_r : ap_cols_r;
  assign ap_shrink = SUM_W'(ap_max) - SUM_W'(ap_prod_r);
  assign ap_full   = (count_r == CW'(MAX_GRIDS));
  assign ap_bad    = (ap_rows_r == '0) || (ap_cols_r == '0) || (ap_off_r < prev_end_r) ||
                     (ap_end > {1'b0, max_ctx_r});

  assign wr_en          = (state_r == S_AP_CHK) && !ap_full && !ap_bad;
  assign wr_data.offset = ap_off_r;
  assign wr_data.rows   = ap_rows_r;
  assign wr_data.cols   = ap_cols_r;

  // walk pipeline: read, multiply, compare
  assign rd_en     = (state_r == S_WALK) && (issue_r < count_r);
  assign s1_max    = (rd_data.rows > rd_data.cols) ? rd_data.rows : rd_data.cols;
  assign s1_prod   = IDX_W'(rd_data.rows * rd_data.cols);
  assign s2_idx    = phys_r - s2_off_r;
  assign delta_nxt = delta_r + s2_shrink_r;
  assign outside_sum = SUM_W'(phys_r) + delta_nxt;
  assign row_sum   = start_r + SUM_W'(div_rsp.quo);
  assign col_sum   = start_r + SUM_W'(div_rsp.rem);

  igpm_table #(
    .DEPTH (MAX_GRIDS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    div_req.vld      = (state_r == S_WALK) && s2_vld_r && (phys_r >= s2_off_r) &&
                       (SUM_W'(s2_idx) < SUM_W'(s2_prod_r));
    div_req.dividend = s2_idx[IDX_W-1:0];
    div_req.divisor  = s2_cols_r;
  end

  igpm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    rd_last_r   <= (issue_r == count_r - 1'b1);
    s2_last_r   <= rd_last_r;
    s2_off_r    <= rd_data.offset;
    s2_cols_r   <= rd_data.cols;
    s2_prod_r   <= s1_prod;
    s2_shrink_r <= SUM_W'(s1_max) - SUM_W'(s1_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      prev_end_r  <= '0;
      shrink_r    <= '0;
      rd_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      s2_vld_r <= rd_vld_r;
      // a finished item reloads the output register below
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= ST_OK;
            // an empty table leaves a queried index unshifted
            res_t_r      <= (kind_t'(in_kind) == KIND_QUERY) ? in_physical_index : '0;
            res_row_r    <= (kind_t'(in_kind) == KIND_QUERY) ? in_physical_index : '0;
            res_col_r    <= (kind_t'(in_kind) == KIND_QUERY) ? in_physical_index : '0;
            ap_off_r     <= in_grid_offset;
            ap_rows_r    <= in_grid_rows;
            ap_cols_r    <= in_grid_cols;
            ap_prod_r    <= IDX_W'(in_grid_rows * in_grid_cols);
            phys_r       <= in_physical_index;
            delta_r      <= '0;
            issue_r      <= '0;
            unique case (kind_t'(in_kind))
              KIND_CLEAR: begin
                count_r    <= '0;
                prev_end_r <= '0;
                shrink_r   <= '0;
                state_r    <= S_DONE;
              end
              KIND_APPEND: state_r <= S_AP_CHK;
              KIND_QUERY: begin
                if (count_r == '0) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_WALK;
                end
              end
              KIND_NONE: state_r <= S_DONE;
              default: state_r <= S_DONE;
            endcase
          end
        end

        S_AP_CHK: begin
          priority if (ap_full) begin
            res_status_r <= ST_FULL;
          end else if (ap_bad) begin
            res_status_r <= ST_BAD_LAYOUT;
          end else begin
            count_r    <= count_r + 1'b1;
            prev_end_r <= ap_end[POS_W-1:0];
            shrink_r   <= shrink_r + ap_shrink;
          end
          state_r <= S_DONE;
        end

        S_WALK: begin
          if (rd_en) begin
            issue_r <= issue_r + 1'b1;
          end
          if (s2_vld_r) begin
            priority if (phys_r < s2_off_r) begin
              // index lies before this grid: shifted by earlier grids only
              res_t_r   <= phys_r + delta_r[POS_W-1:0];
              res_row_r <= phys_r + delta_r[POS_W-1:0];
              res_col_r <= phys_r + delta_r[POS_W-1:0];
              state_r   <= S_DONE;
            end else if (div_req.vld) begin
              start_r <= SUM_W'(s2_off_r) + delta_r;
              state_r <= S_DIV;
            end else begin
              delta_r <= delta_nxt;
              if (s2_last_r) begin
                res_t_r   <= outside_sum[POS_W-1:0];
                res_row_r <= outside_sum[POS_W-1:0];
                res_col_r <= outside_sum[POS_W-1:0];
                state_r   <= S_DONE;
              end
            end
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            res_t_r   <= start_r[POS_W-1:0];
            res_row_r <= row_sum[POS_W-1:0];
            res_col_r <= col_sum[POS_W-1:0];
            state_r   <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_t_r      <= res_t_r;
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            out_shrink_r <= shrink_r;
            out_prefix_r <= prev_end_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_pos_temporal  = out_t_r;
  assign out_pos_row       = out_row_r;
  assign out_pos_col       = out_col_r;
  assign out_total_shrink  = out_shrink_r;
  assign out_prefix_length = out_prefix_r;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import igpm_pkg::*;

  localparam int unsigned GRID_SLOTS  = 256;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint      POS_MASK    = 64'h7FFF_FFFF;
  localparam longint      CTX_MAX     = 64'h7FFF_FFFF;
  localparam longint      CTX_RESET   = 32768;
  localparam logic [2:0]  ADDR_CTX_LIMIT = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED  = 3'd4;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_kind = KIND_NONE;
  logic [POS_W-1:0]        in_grid_offset = '0;
  logic [DIM_W-1:0]        in_grid_rows = '0;
  logic [DIM_W-1:0]        in_grid_cols = '0;
  logic [POS_W-1:0]        in_physical_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_status;
  logic [POS_W-1:0]        out_pos_temporal;
  logic [POS_W-1:0]        out_pos_row;
  logic [POS_W-1:0]        out_pos_col;
  logic signed [SUM_W-1:0] out_total_shrink;
  logic [POS_W-1:0]        out_prefix_length;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  image_grid_position_mapper_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_grid_offset    (in_grid_offset),
    .in_grid_rows      (in_grid_rows),
    .in_grid_cols      (in_grid_cols),
    .in_physical_index (in_physical_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_pos_temporal  (out_pos_temporal),
    .out_pos_row       (out_pos_row),
    .out_pos_col       (out_pos_col),
    .out_total_shrink  (out_total_shrink),
    .out_prefix_length (out_prefix_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  typedef struct {
    status_t              status;
    logic [POS_W-1:0]     temporal;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [SUM_W-1:0]     shrink;
    logic [POS_W-1:0]     prefix;
  } position_set_t;

  // shadow of the grid table
  logic [POS_W-1:0] grid_off  [GRID_SLOTS];
  logic [DIM_W-1:0] grid_rows [GRID_SLOTS];
  logic [DIM_W-1:0] grid_cols [GRID_SLOTS];
  int unsigned      grid_count = 0;
  longint           grid_end = 0;
  longint           shrink_acc = 0;
  longint           ctx_limit = CTX_RESET;

  position_set_t pending_positions[$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int unsigned idle_cycles = 0;
  int          err_count = 0;
  int unsigned n_items = 0;
  int unsigned n_kept = 0;
  int unsigned n_bad_layout = 0;
  int unsigned n_full = 0;
  int unsigned n_inside = 0;
  int unsigned n_checked = 0;

  function automatic longint area_shrink(longint r, longint c);
    return ((r > c) ? r : c) - r * c;
  endfunction

  task automatic compute_positions(input kind_t kind, input logic [POS_W-1:0] off,
                                   input logic [DIM_W-1:0] rows,
                                   input logic [DIM_W-1:0] cols,
                                   input logic [POS_W-1:0] phys,
                                   output position_set_t res);
    longint cnt;
    longint delta;
    longint start;
    longint idx;
    longint v;
    bit     found;
    res.status   = ST_OK;
    res.temporal = '0;
    res.row      = '0;
    res.col      = '0;
    case (kind)
      KIND_CLEAR: begin
        grid_count = 0;
        grid_end   = 0;
        shrink_acc = 0;
      end
      KIND_APPEND: begin
        cnt = longint'(rows) * longint'(cols);
        if (grid_count >= GRID_SLOTS) begin
          res.status = ST_FULL;
          n_full++;
        end else if (rows == 0 || cols == 0 || longint'(off) < grid_end ||
                     longint'(off) + cnt > ctx_limit) begin
          res.status = ST_BAD_LAYOUT;
          n_bad_layout++;
        end else begin
          grid_off[grid_count]  = off;
          grid_rows[grid_count] = rows;
          grid_cols[grid_count] = cols;
          grid_count++;
          grid_end   = (longint'(off) + cnt) & POS_MASK;
          shrink_acc += area_shrink(rows, cols);
          n_kept++;
        end
      end
      KIND_QUERY: begin
        delta = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < grid_count; i++) begin
          if (longint'(phys) < longint'(grid_off[i])) break;
          cnt = longint'(grid_rows[i]) * longint'(grid_cols[i]);
          idx = longint'(phys) - longint'(grid_off[i]);
          if (idx < cnt && grid_cols[i] != 0) begin
            start        = longint'(grid_off[i]) + delta;
            res.temporal = start[POS_W-1:0];
            v            = start + idx / longint'(grid_cols[i]);
            res.row      = v[POS_W-1:0];
            v            = start + idx % longint'(grid_cols[i]);
            res.col      = v[POS_W-1:0];
            found        = 1'b1;
            n_inside++;
            break;
          end
          delta += area_shrink(grid_rows[i], grid_cols[i]);
        end
        if (!found) begin
          v            = longint'(phys) + delta;
          res.temporal = v[POS_W-1:0];
          res.row      = v[POS_W-1:0];
          res.col      = v[POS_W-1:0];
        end
      end
      default: ;
    endcase
    res.shrink = shrink_acc[SUM_W-1:0];
    res.prefix = grid_end[POS_W-1:0];
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // result side: random stall, or a long hold when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    position_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_positions.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_positions.pop_front();
        n_checked++;
        check_field("status", {30'b0, want.status}, {30'b0, out_status});
        check_field("pos_temporal", {1'b0, want.temporal}, {1'b0, out_pos_temporal});
        check_field("pos_row", {1'b0, want.row}, {1'b0, out_pos_row});
        check_field("pos_col", {1'b0, want.col}, {1'b0, out_pos_col});
        check_field("total_shrink", want.shrink, out_total_shrink);
        check_field("prefix_length", {1'b0, want.prefix}, {1'b0, out_prefix_length});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat for %0d cycles", STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_item(input kind_t kind, input logic [POS_W-1:0] off,
                           input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                           input logic [POS_W-1:0] phys);
    position_set_t res;
    int            gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid          = 1'b1;
    in_kind           = kind;
    in_grid_offset    = off;
    in_grid_rows      = rows;
    in_grid_cols      = cols;
    in_physical_index = phys;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_positions(kind, off, rows, cols, phys, res);
    pending_positions.insert(pending_positions.size(), res);
    n_items++;
  endtask

  task automatic send_append(input longint off, input logic [DIM_W-1:0] rows,
                             input logic [DIM_W-1:0] cols);
    send_item(KIND_APPEND, off[POS_W-1:0], rows, cols, POS_W'($urandom));
  endtask

  task automatic send_query(input longint phys);
    send_item(KIND_QUERY, POS_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
              phys[POS_W-1:0]);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, POS_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
              POS_W'($urandom));
  endtask

  // drop valid, then wait for every expected result plus a settling gap
  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_CTX_LIMIT) ctx_limit = longint'(data) & POS_MASK;
    // read back the only register
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_CTX_LIMIT;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("ctx_limit", {1'b0, ctx_limit[POS_W-1:0]}, {1'b0, prdata[POS_W-1:0]});
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic longint pick_query_phys();
    int unsigned i;
    longint      cnt;
    longint      p;
    i   = (grid_count != 0) ? $urandom_range(0, grid_count - 1) : 0;
    cnt = longint'(grid_rows[i]) * longint'(grid_cols[i]);
    case ($urandom_range(7))
      0, 1, 2, 3: p = (grid_count != 0) ? grid_off[i] + $urandom_range(0, 32'(cnt - 1))
                                        : $urandom_range(0, 100);
      4: p = grid_end + $urandom_range(0, 50);
      5: p = POS_W'($urandom);
      6: p = (grid_count != 0 && grid_off[i] > 5) ? grid_off[i] - $urandom_range(1, 5) : 0;
      default: p = (grid_count != 0) ? grid_off[i] + cnt : $urandom_range(0, 100);
    endcase
    return p & POS_MASK;
  endfunction

  // append a grid that normally fits behind the last one
  task automatic send_fresh_grid(input bit wide);
    longint           base;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    int               mode;
    base = grid_end;
    if (grid_count == 0 && $urandom_range(3) == 0)
      base = $urandom_range(0, 32'(ctx_limit / 2));
    base += ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 40);
    mode = wide ? $urandom_range(9) : 0;
    case (mode)
      7: begin
        r = DIM_W'($urandom_range(1, 4095));
        c = DIM_W'($urandom_range(1, 3));
      end
      8: begin
        r = DIM_W'($urandom_range(1, 3));
        c = DIM_W'($urandom_range(1, 4095));
      end
      9: begin
        r = DIM_W'($urandom_range(1, 300));
        c = DIM_W'($urandom_range(1, 300));
      end
      default: begin
        r = DIM_W'($urandom_range(1, wide ? 16 : 6));
        c = DIM_W'($urandom_range(1, wide ? 16 : 6));
      end
    endcase
    send_append(base, r, c);
  endtask

  task automatic test_directed_cases();
    longint top_off;
    top_off = CTX_MAX - 4095 * 4095;
    send_query(0);
    send_query(CTX_MAX);
    send_append(0, 0, 5);
    send_append(0, 5, 0);
    send_append(10, 4, 3);
    send_append(21, 1, 1);          // overlaps the previous grid
    send_append(22, 1, 4095);
    send_append(5000, 200, 200);    // runs past the context
    send_append(4117, 2, 2);        // starts exactly at the previous end
    send_query(5);
    send_query(10);
    send_query(21);
    send_query(22);
    send_query(4116);
    send_query(5000);
    send_item(KIND_NONE, POS_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
              POS_W'($urandom));
    send_query(CTX_MAX);
    send_clear();
    wait_drained(8);
    cfg_write(ADDR_UNMAPPED, $urandom);
    cfg_write(ADDR_CTX_LIMIT, 32'd1);
    send_append(0, 1, 1);
    send_clear();
    send_append(1, 1, 1);
    send_append(0, 1, 2);
    wait_drained(8);
    cfg_write(ADDR_CTX_LIMIT, 32'(CTX_MAX));
    send_append(top_off, 4095, 4095);
    send_query(top_off + 4095 * 4095 - 1);
    send_append(CTX_MAX, 1, 1);
    send_query(0);
    send_clear();
  endtask

  task automatic test_random_layouts(input int unsigned count, input longint ctx);
    int unsigned first_item;
    int unsigned ngrids;
    longint      off;
    logic [DIM_W-1:0] r;
    wait_drained(8);
    cfg_write(ADDR_CTX_LIMIT, 32'(ctx));
    first_item = n_items;
    while (n_items - first_item < count) begin
      send_clear();
      ngrids = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int unsigned g = 0; g < ngrids; g++) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(4))
            0: send_item(KIND_NONE, POS_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                         POS_W'($urandom));
            1: begin
              off = (grid_end > 0) ? grid_end - $urandom_range(1, 32'(grid_end)) : 0;
              send_append(off, DIM_W'($urandom_range(grid_end > 0 ? 1 : 0, 8)),
                          DIM_W'($urandom_range(1, 8)));
            end
            2: begin
              r = ($urandom_range(1) == 0) ? '0 : DIM_W'($urandom);
              send_append(grid_end, r, (r == '0) ? DIM_W'($urandom) : '0);
            end
            3: send_append(ctx_limit - $urandom_range(0, 10),
                           DIM_W'($urandom_range(64, 4095)),
                           DIM_W'($urandom_range(64, 4095)));
            default: send_item(kind_t'($urandom_range(3)), POS_W'($urandom),
                               DIM_W'($urandom), DIM_W'($urandom), POS_W'($urandom));
          endcase
        end else begin
          send_fresh_grid(1'b1);
        end
        repeat ($urandom_range(0, 2)) send_query(pick_query_phys());
      end
    end
  endtask

  task automatic test_full_table();
    wait_drained(8);
    cfg_write(ADDR_CTX_LIMIT, 32'(CTX_MAX));
    send_clear();
    for (int k = 0; k < GRID_SLOTS; k++) begin
      send_fresh_grid(1'b0);
      if (k % 32 == 31) send_query(pick_query_phys());
    end
    // every refusal here must report the full table first
    send_fresh_grid(1'b0);
    send_append(grid_end, 0, 0);
    send_append(0, 3, 3);
    repeat (8) send_query(pick_query_phys());
    send_clear();
    send_query(pick_query_phys());
  endtask

  task automatic test_backpressure_fill();
    wait_drained(8);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (30) begin
      if ($urandom_range(2) == 0) send_fresh_grid(1'b1);
      else send_query(pick_query_phys());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 36;
    rx_idle_pct = 57;
    test_directed_cases();
    test_random_layouts(240, CTX_MAX);
    test_full_table();

    tx_idle_pct = 57;
    rx_idle_pct = 36;
    test_random_layouts(240, $urandom_range(20000, 200000));
    test_backpressure_fill();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_layouts(240, $urandom_range(200000, 50000000));
    wait_drained(300);

    $display("coverage: %0d items, %0d grids stored, %0d bad layouts, %0d full-table refusals",
             n_items, n_kept, n_bad_layout, n_full);
    $display("coverage: %0d queries inside a grid, %0d results compared", n_inside, n_checked);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/igpm_pkg.sv
src/igpm_table.sv
src/igpm_divider.sv
src/image_grid_position_mapper_core.sv
verif/tb_top.sv
